// ===== hw/rtl/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg
// Shared constants and controller/datapath types for the sequence pair packer.
// ----------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

    // defaults for the top-level parameters
    localparam int MAX_MACROS_DEF = 32;
    localparam int DIM_BITS_DEF   = 24;

    // fixed field widths on the word interfaces
    localparam int SLOT_W  = 5;
    localparam int DIM_W   = 24;
    localparam int COORD_W = 32;

    // configuration register file
    localparam int          CFG_W            = 6;
    localparam int          PADDR_W          = 3;
    localparam int          PDATA_W          = 32;
    localparam logic        REG_NUM_MACROS   = 1'b0;
    localparam logic [5:0]  NUM_MACROS_RESET = 6'd32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the accepted input word
        logic pack_start;  // clear rank and placement valid bits, rewind i
        logic rank_step;   // build one negative-sequence rank
        logic pass_start;  // clear running lengths, rewind i, select pass
        logic pass_y;      // pass selected by pass_start: 1 for y
        logic pick;        // read next macro of the positive order
        logic fetch;       // read rank and size of the picked macro
        logic base;        // place the macro at its running length
        logic raise;       // raise one running length
        logic total;       // latch the bounding size of the pass
        logic emit_start;  // rewind the result counter
        logic emit_step;   // load one result word into the output register
    } spp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic i_end;       // walk counter reached the macro count
        logic b_skip;      // picked entry lies beyond the macro count
        logic raise_go;    // current running length must be raised
        logic k_end;       // all result words issued
        logic out_free;    // output register can take a word
    } spp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spp_if.sv =====
// ----------------------------------------------------------------------------
// spp_if
// Valid/ready word channels: slot loads in, placements out.
// ----------------------------------------------------------------------------
`default_nettype none

interface spp_load_if
    import spp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   pos_entry;
    logic [SLOT_W-1:0]   neg_entry;
    logic [DIM_W-1:0]    macro_width;
    logic [DIM_W-1:0]    macro_height;
    logic                load_last;

    modport source (output valid, slot, pos_entry, neg_entry, macro_width,
                    macro_height, load_last, input ready);
    modport sink   (input valid, slot, pos_entry, neg_entry, macro_width,
                    macro_height, load_last, output ready);
endinterface

interface spp_result_if
    import spp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   macro_index;
    logic [COORD_W-1:0]  x_pos;
    logic [COORD_W-1:0]  y_pos;
    logic [COORD_W-1:0]  total_width;
    logic [COORD_W-1:0]  total_height;
    logic                result_last;

    modport source (output valid, macro_index, x_pos, y_pos, total_width,
                    total_height, result_last, input ready);
    modport sink   (input valid, macro_index, x_pos, y_pos, total_width,
                    total_height, result_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spp_datapath.sv =====
// ----------------------------------------------------------------------------
// spp_datapath
// Sequence stores, rank table, running lengths, placements and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_datapath
    import spp_pkg::*;
#(
    parameter int MAX_MACROS = MAX_MACROS_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_MACROS),
    localparam int CNT_W     = $clog2(MAX_MACROS + 1)
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CNT_W-1:0]   n,
    input  wire spp_cmd_t           cmd,
    output spp_sts_t                sts,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [SLOT_W-1:0]  pos_entry,
    input  wire logic [SLOT_W-1:0]  neg_entry,
    input  wire logic [DIM_W-1:0]   macro_width,
    input  wire logic [DIM_W-1:0]   macro_height,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [SLOT_W-1:0]       out_index,
    output logic [COORD_W-1:0]      out_x,
    output logic [COORD_W-1:0]      out_y,
    output logic [COORD_W-1:0]      out_tw,
    output logic [COORD_W-1:0]      out_th,
    output logic                    out_last
);

    // stores
    logic [SLOT_W-1:0]   pos_mem [MAX_MACROS];
    logic [SLOT_W-1:0]   neg_mem [MAX_MACROS];
    logic [DIM_BITS-1:0] wid_mem [MAX_MACROS];
    logic [DIM_BITS-1:0] hgt_mem [MAX_MACROS];
    logic [IDX_W-1:0]    rank_mem [MAX_MACROS];
    logic [COORD_W-1:0]  rl_mem [MAX_MACROS];
    logic [COORD_W-1:0]  x_mem [MAX_MACROS];
    logic [COORD_W-1:0]  y_mem [MAX_MACROS];

    logic [MAX_MACROS-1:0] rank_vld_reg, rank_vld_next;
    logic [MAX_MACROS-1:0] rl_vld_reg, rl_vld_next;
    logic [MAX_MACROS-1:0] x_vld_reg, x_vld_next;
    logic [MAX_MACROS-1:0] y_vld_reg, y_vld_next;

    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                dir_reg, dir_next;
    logic [IDX_W-1:0]    b_reg, b_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [DIM_BITS-1:0] size_reg, size_next;
    logic [COORD_W-1:0]  t_reg, t_next;
    logic [COORD_W-1:0]  tw_reg, tw_next;
    logic [COORD_W-1:0]  th_reg, th_next;
    logic                ov_reg, ov_next;

    logic [IDX_W-1:0]    pos_addr;
    logic [SLOT_W-1:0]   pos_rd;
    logic [SLOT_W-1:0]   neg_rd;
    logic [IDX_W-1:0]    rl_addr;
    logic [COORD_W-1:0]  rl_rd;
    logic [IDX_W-1:0]    k_idx;
    logic [COORD_W-1:0]  sum;
    logic                slot_ok;
    logic                neg_ok;

    // read ports
    always_comb
    begin
        pos_addr = dir_reg ? IDX_W'(n - CNT_W'(1) - i_reg) : IDX_W'(i_reg);
        pos_rd   = pos_mem[pos_addr];
        neg_rd   = neg_mem[IDX_W'(i_reg)];
        if (cmd.base)
            rl_addr = p_reg;
        else if (cmd.total)
            rl_addr = IDX_W'(n - CNT_W'(1));
        else
            rl_addr = IDX_W'(j_reg);
        rl_rd    = rl_vld_reg[rl_addr] ? rl_mem[rl_addr] : '0;
        k_idx    = IDX_W'(k_reg);
        sum      = rl_rd + COORD_W'(size_reg);
        slot_ok  = 32'(slot) < MAX_MACROS;
        neg_ok   = 32'(neg_rd) < 32'(n);
    end

    // status
    always_comb
    begin
        sts.i_end    = (i_reg == n);
        sts.b_skip   = 32'(pos_rd) >= 32'(n);
        sts.raise_go = (j_reg < n) && (t_reg > rl_rd);
        sts.k_end    = (k_reg == n);
        sts.out_free = !ov_reg || out_ready;
    end

    // next-state logic for counters, valid bits and payload registers
    always_comb
    begin
        rank_vld_next = rank_vld_reg;
        rl_vld_next   = rl_vld_reg;
        x_vld_next    = x_vld_reg;
        y_vld_next    = y_vld_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        dir_next      = dir_reg;
        b_next        = b_reg;
        p_next        = p_reg;
        size_next     = size_reg;
        t_next        = t_reg;
        tw_next       = tw_reg;
        th_next       = th_reg;
        ov_next       = ov_reg;

        if (cmd.pack_start)
        begin
            rank_vld_next = '0;
            x_vld_next    = '0;
            y_vld_next    = '0;
            i_next        = '0;
        end
        if (cmd.rank_step)
        begin
            if (neg_ok)
                rank_vld_next[IDX_W'(neg_rd)] = 1'b1;
            i_next = i_reg + CNT_W'(1);
        end
        if (cmd.pass_start)
        begin
            rl_vld_next = '0;
            i_next      = '0;
            dir_next    = cmd.pass_y;
        end
        if (cmd.pick)
        begin
            b_next = IDX_W'(pos_rd);
            if (sts.b_skip)
                i_next = i_reg + CNT_W'(1);
        end
        if (cmd.fetch)
        begin
            p_next    = rank_vld_reg[b_reg] ? rank_mem[b_reg] : '0;
            size_next = dir_reg ? hgt_mem[b_reg] : wid_mem[b_reg];
        end
        if (cmd.base)
        begin
            t_next = sum;
            j_next = CNT_W'(p_reg);
            i_next = i_reg + CNT_W'(1);
            if (dir_reg)
                y_vld_next[b_reg] = 1'b1;
            else
                x_vld_next[b_reg] = 1'b1;
        end
        if (cmd.raise && sts.raise_go)
        begin
            rl_vld_next[IDX_W'(j_reg)] = 1'b1;
            j_next = j_reg + CNT_W'(1);
        end
        if (cmd.total)
        begin
            if (dir_reg)
                th_next = rl_rd;
            else
                tw_next = rl_rd;
        end
        if (cmd.emit_start)
            k_next = '0;

        // output register
        if (cmd.emit_step)
        begin
            ov_next = 1'b1;
            k_next  = k_reg + CNT_W'(1);
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_vld_reg <= '0;
            rl_vld_reg   <= '0;
            x_vld_reg    <= '0;
            y_vld_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            dir_reg      <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            rank_vld_reg <= rank_vld_next;
            rl_vld_reg   <= rl_vld_next;
            x_vld_reg    <= x_vld_next;
            y_vld_reg    <= y_vld_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            dir_reg      <= dir_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers and stores
    always_ff @(posedge clk)
    begin
        b_reg    <= b_next;
        p_reg    <= p_next;
        size_reg <= size_next;
        t_reg    <= t_next;
        tw_reg   <= tw_next;
        th_reg   <= th_next;

        if (cmd.load && slot_ok)
        begin
            pos_mem[IDX_W'(slot)] <= pos_entry;
            neg_mem[IDX_W'(slot)] <= neg_entry;
            wid_mem[IDX_W'(slot)] <= DIM_BITS'(32'(macro_width));
            hgt_mem[IDX_W'(slot)] <= DIM_BITS'(32'(macro_height));
        end
        if (cmd.rank_step && neg_ok)
            rank_mem[IDX_W'(neg_rd)] <= IDX_W'(i_reg);
        if (cmd.base)
        begin
            if (dir_reg)
                y_mem[b_reg] <= rl_rd;
            else
                x_mem[b_reg] <= rl_rd;
        end
        if (cmd.raise && sts.raise_go)
            rl_mem[IDX_W'(j_reg)] <= t_reg;

        // result word
        if (cmd.emit_step)
        begin
            out_index <= SLOT_W'(k_reg);
            out_x     <= x_vld_reg[k_idx] ? x_mem[k_idx] : '0;
            out_y     <= y_vld_reg[k_idx] ? y_mem[k_idx] : '0;
            out_last  <= (k_reg == n - CNT_W'(1));
            out_tw    <= (k_reg == n - CNT_W'(1)) ? tw_reg : '0;
            out_th    <= (k_reg == n - CNT_W'(1)) ? th_reg : '0;
        end
    end

    assign out_valid = ov_reg;

    // checks
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> sts.out_free)
        else $error("result word loaded over an unread word");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_ready && out_last) |=> !ov_reg)
        else $error("result word follows the last word at once");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> (i_reg < n))
        else $error("positive order read beyond the macro count");

endmodule

`default_nettype wire

// ===== hw/rtl/spp_ctrl.sv =====
// ----------------------------------------------------------------------------
// spp_ctrl
// Sequencer for load, rank build, the x and y packing passes and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module spp_ctrl
    import spp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_last,
    output logic           in_ready,
    input  wire spp_sts_t  sts,
    output spp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANK,
        ST_PICK,
        ST_FETCH,
        ST_BASE,
        ST_RAISE,
        ST_TOTAL,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ypass_reg, ypass_next;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ypass_next = ypass_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.pack_start = 1'b1;
                        state_next     = ST_RANK;
                    end
                end
            end
            ST_RANK:
            begin
                if (sts.i_end)
                begin
                    cmd.pass_start = 1'b1;
                    cmd.pass_y     = 1'b0;
                    ypass_next     = 1'b0;
                    state_next     = ST_PICK;
                end
                else
                begin
                    cmd.rank_step = 1'b1;
                end
            end
            ST_PICK:
            begin
                if (sts.i_end)
                begin
                    state_next = ST_TOTAL;
                end
                else
                begin
                    cmd.pick = 1'b1;
                    if (!sts.b_skip)
                        state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = ST_RAISE;
            end
            ST_RAISE:
            begin
                cmd.raise = 1'b1;
                if (!sts.raise_go)
                    state_next = ST_PICK;
            end
            ST_TOTAL:
            begin
                cmd.total = 1'b1;
                if (ypass_reg)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    cmd.pass_start = 1'b1;
                    cmd.pass_y     = 1'b1;
                    ypass_next     = 1'b1;
                    state_next     = ST_PICK;
                end
            end
            ST_EMIT:
            begin
                if (sts.k_end)
                    state_next = ST_IDLE;
                else if (sts.out_free)
                    cmd.emit_step = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ypass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ypass_reg <= ypass_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sequence_pair_pack_core.sv =====
// ----------------------------------------------------------------------------
// sequence_pair_pack_core
// Sequence pair floorplan evaluator: loads slots, packs, issues placements.
// ----------------------------------------------------------------------------
// Load one slot per word; the word flagged load_last starts packing, after
// which the core takes no load word until every placement word has been
// issued. Packing first builds the ranks, then runs an x pass and a y pass;
// each pass skips positive-order entries beyond the macro count, places each
// other macro in pick, fetch, base and raise steps, raising one running
// length at a time through the single-ported running-length store, and
// closes with a total step. Placement words follow at one per cycle while
// the sink keeps up. num_macros sits at byte address 0 of the register port.
`default_nettype none

module sequence_pair_pack_core
    import spp_pkg::*;
#(
    parameter int MAX_MACROS = MAX_MACROS_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    spp_load_if.sink                 load,
    spp_result_if.source             result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int CNT_W = $clog2(MAX_MACROS + 1);

    logic [CFG_W-1:0] num_reg;
    logic [CNT_W-1:0] n;
    spp_cmd_t         cmd;
    spp_sts_t         sts;
    logic             reg_hit;

    // register port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_NUM_MACROS);
    assign prdata  = reg_hit ? PDATA_W'(num_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_reg <= NUM_MACROS_RESET;
        else if (psel && penable && pwrite && reg_hit)
            num_reg <= pwdata[CFG_W-1:0];
    end

    // clamp macro count into 1..MAX_MACROS
    always_comb
    begin
        if (num_reg == '0)
            n = CNT_W'(1);
        else if (32'(num_reg) > MAX_MACROS)
            n = CNT_W'(MAX_MACROS);
        else
            n = CNT_W'(num_reg);
    end

    spp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (load.valid),
        .in_last  (load.load_last),
        .in_ready (load.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spp_datapath #(
        .MAX_MACROS (MAX_MACROS),
        .DIM_BITS   (DIM_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .n            (n),
        .cmd          (cmd),
        .sts          (sts),
        .slot         (load.slot),
        .pos_entry    (load.pos_entry),
        .neg_entry    (load.neg_entry),
        .macro_width  (load.macro_width),
        .macro_height (load.macro_height),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_index    (result.macro_index),
        .out_x        (result.x_pos),
        .out_y        (result.y_pos),
        .out_tw       (result.total_width),
        .out_th       (result.total_height),
        .out_last     (result.result_last)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sequence_pair_pack_core: loads sequence pairs,
// predicts every placement word and compares it with the core's output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import spp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 32;
    localparam int STALL_MAX  = 5000;
    localparam int SETTLE     = 12;
    localparam int LONG_HOLD  = 300;

    typedef struct {
        logic [4:0]  slot;
        logic [4:0]  pos_entry;
        logic [4:0]  neg_entry;
        logic [23:0] macro_width;
        logic [23:0] macro_height;
        logic        load_last;
    } load_word_t;

    typedef struct {
        logic [4:0]  macro_index;
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [31:0] total_width;
        logic [31:0] total_height;
        logic        result_last;
    } placement_t;

    typedef struct {
        bit          is_cfg;
        logic [5:0]  cfg_value;
        load_word_t  word;
        bit          typed;
        placement_t  typed_place;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    spp_load_if   load ();
    spp_result_if result ();

    sequence_pair_pack_core uut (
        .clk(clk), .rst_n(rst_n), .load(load.sink), .result(result.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the core's stores
    logic [4:0]  sh_pos [SLOTS];
    logic [4:0]  sh_neg [SLOTS];
    logic [23:0] sh_wid [SLOTS];
    logic [23:0] sh_hgt [SLOTS];
    logic [5:0]  sh_count = NUM_MACROS_RESET;

    placement_t placements_due[$];
    int  fail_count = 0;
    int  stall_cycles = 0;
    bit  idling_on = 1'b1;
    bit  long_hold_armed = 1'b0;
    int  hold_left = 0;
    int  burst_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        load.valid = 1'b0;
        load.slot = '0;
        load.pos_entry = '0;
        load.neg_entry = '0;
        load.macro_width = '0;
        load.macro_height = '0;
        load.load_last = 1'b0;
    end

    // one packing walk over the positive order, forward for x, backward for y
    function automatic void walk_pass(input int n, input bit vertical,
                                      input logic [4:0] rank [SLOTS],
                                      output logic [31:0] coord [SLOTS],
                                      output logic [31:0] extent);
        logic [31:0] run [SLOTS];
        logic [31:0] base, top;
        logic [4:0]  b;
        int p;
        for (int i = 0; i < SLOTS; i++)
        begin
            run[i] = '0;
            coord[i] = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            b = vertical ? sh_pos[n-1-i] : sh_pos[i];
            if (b < n)
            begin
                p = rank[b];
                base = run[p];
                top = base + (vertical ? {8'd0, sh_hgt[b]} : {8'd0, sh_wid[b]});
                for (int j = p; j < n; j++)
                begin
                    if (top > run[j])
                        run[j] = top;
                    else
                        break;
                end
                coord[b] = base;
            end
        end
        extent = run[n-1];
    endfunction

    // store one word; a final word packs and yields one placement per macro
    function automatic void predict_placements(input load_word_t w,
                                               output placement_t res[$]);
        logic [4:0]  rank [SLOTS];
        logic [31:0] xs [SLOTS], ys [SLOTS];
        logic [31:0] tw, th;
        placement_t  pl;
        int n;
        res = {};
        sh_pos[w.slot] = w.pos_entry;
        sh_neg[w.slot] = w.neg_entry;
        sh_wid[w.slot] = w.macro_width;
        sh_hgt[w.slot] = w.macro_height;
        if (!w.load_last)
            return;
        n = (sh_count == 0) ? 1 : ((sh_count > SLOTS) ? SLOTS : int'(sh_count));
        for (int i = 0; i < SLOTS; i++)
            rank[i] = '0;
        for (int i = 0; i < n; i++)
            if (sh_neg[i] < n)
                rank[sh_neg[i]] = i[4:0];
        walk_pass(n, 1'b0, rank, xs, tw);
        walk_pass(n, 1'b1, rank, ys, th);
        for (int k = 0; k < n; k++)
        begin
            pl.macro_index = k[4:0];
            pl.x_pos = xs[k];
            pl.y_pos = ys[k];
            pl.result_last = (k == n - 1);
            pl.total_width = pl.result_last ? tw : '0;
            pl.total_height = pl.result_last ? th : '0;
            res.insert(res.size(), pl);
        end
    endfunction

    // register write, setup then access
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == PADDR_W'(0))
            sh_count = data[5:0];
    endtask

    // wait until the core has drained, then let it settle
    task automatic wait_drained();
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input load_word_t w, input bit typed,
                             input placement_t typed_place);
        placement_t res[$];
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            load.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        load.valid <= 1'b1;
        load.slot <= w.slot;
        load.pos_entry <= w.pos_entry;
        load.neg_entry <= w.neg_entry;
        load.macro_width <= w.macro_width;
        load.macro_height <= w.macro_height;
        load.load_last <= w.load_last;
        @(posedge clk);
        while (!load.ready)
            @(posedge clk);
        predict_placements(w, res);
        if (typed)
            placements_due.insert(placements_due.size(), typed_place);
        else
            foreach (res[i])
                placements_due.insert(placements_due.size(), res[i]);
    endtask

    task automatic end_words();
        load.valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_dim();
        case ($urandom_range(0, 3))
            0: rand_dim = 24'($urandom);
            1: rand_dim = 24'($urandom_range(0, 15));
            2: rand_dim = 24'hFFFFFF - 24'($urandom_range(0, 3));
            default: rand_dim = 24'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic void shuffle(input int n, output logic [4:0] perm [SLOTS]);
        int j;
        logic [4:0] t;
        for (int i = 0; i < SLOTS; i++)
            perm[i] = i[4:0];
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
    endfunction

    // one load set: every slot below n written in shuffled order, stray random words mixed in, final word last
    task automatic send_set(input int n);
        logic [4:0] order [SLOTS], pp [SLOTS], np [SLOTS];
        load_word_t w;
        placement_t none;
        bit broken;
        broken = ($urandom_range(0, 3) == 0);
        shuffle(n, order);
        shuffle(n, pp);
        shuffle(n, np);
        none = '{default: '0};
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                w.slot = 5'($urandom);
                w.pos_entry = 5'($urandom);
                w.neg_entry = 5'($urandom);
                w.macro_width = rand_dim();
                w.macro_height = rand_dim();
                w.load_last = 1'b0;
                send_word(w, 1'b0, none);
            end
            w.slot = order[i];
            w.pos_entry = broken ? 5'($urandom) : pp[order[i]];
            w.neg_entry = broken ? 5'($urandom) : np[order[i]];
            w.macro_width = rand_dim();
            w.macro_height = rand_dim();
            w.load_last = (i == n - 1);
            send_word(w, 1'b0, none);
        end
    endtask

    // placement checker and sink idling
    always @(posedge clk)
    begin
        placement_t exp_pl;
        if (result.valid && result.ready)
        begin
            if (placements_due.size() == 0)
            begin
                $error("placement word with none expected: index %0d", result.macro_index);
                fail_count++;
            end
            else
            begin
                exp_pl = placements_due.pop_front();
                if (result.macro_index !== exp_pl.macro_index)
                begin
                    $error("macro_index: expected %0d, got %0d",
                           exp_pl.macro_index, result.macro_index);
                    fail_count++;
                end
                if (result.x_pos !== exp_pl.x_pos)
                begin
                    $error("x_pos: expected %0d, got %0d", exp_pl.x_pos, result.x_pos);
                    fail_count++;
                end
                if (result.y_pos !== exp_pl.y_pos)
                begin
                    $error("y_pos: expected %0d, got %0d", exp_pl.y_pos, result.y_pos);
                    fail_count++;
                end
                if (result.total_width !== exp_pl.total_width)
                begin
                    $error("total_width: expected %0d, got %0d",
                           exp_pl.total_width, result.total_width);
                    fail_count++;
                end
                if (result.total_height !== exp_pl.total_height)
                begin
                    $error("total_height: expected %0d, got %0d",
                           exp_pl.total_height, result.total_height);
                    fail_count++;
                end
                if (result.result_last !== exp_pl.result_last)
                begin
                    $error("result_last: expected %0d, got %0d",
                           exp_pl.result_last, result.result_last);
                    fail_count++;
                end
            end
        end
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result.ready <= 1'b0;
        end
        else if (long_hold_armed && result.valid)
        begin
            long_hold_armed <= 1'b0;
            hold_left <= LONG_HOLD;
            result.ready <= 1'b0;
        end
        else if (burst_left > 0)
        begin
            burst_left <= burst_left - 1;
            result.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            burst_left <= $urandom_range(0, 3);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((load.valid && load.ready) || (result.valid && result.ready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("sequence_pair_pack_core test failed");
            $finish;
        end
    end

    // directed table then random sets
    initial
    begin
        stim_row_t rows[$];
        stim_row_t r;
        int counts[$];
        int sent;
        int n;
        int sets;

        // single macro at the size extremes, then a small legal pair, then
        // out-of-range entries, a duplicate and a macro missing from both orders
        r = '{default: '0};
        r.is_cfg = 1'b1; r.cfg_value = 6'd0; rows.insert(rows.size(), r);
        r = '{default: '0};
        r.word = '{5'd0, 5'd0, 5'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1};
        r.typed = 1'b1;
        r.typed_place = '{5'd0, 32'd0, 32'd0, 32'hFFFFFF, 32'hFFFFFF, 1'b1};
        rows.insert(rows.size(), r);
        r.word = '{5'd0, 5'd0, 5'd0, 24'h0, 24'h0, 1'b1};
        r.typed_place = '{5'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
        rows.insert(rows.size(), r);
        r = '{default: '0};
        r.is_cfg = 1'b1; r.cfg_value = 6'd2; rows.insert(rows.size(), r);
        r = '{default: '0};
        r.word = '{5'd1, 5'd1, 5'd1, 24'd5, 24'd7, 1'b0}; rows.insert(rows.size(), r);
        r.word = '{5'd0, 5'd0, 5'd0, 24'd3, 24'd4, 1'b1}; rows.insert(rows.size(), r);
        r.word = '{5'd0, 5'd1, 5'd0, 24'd9, 24'd2, 1'b0}; rows.insert(rows.size(), r);
        r.word = '{5'd1, 5'd0, 5'd1, 24'd6, 24'd8, 1'b1}; rows.insert(rows.size(), r);
        r = '{default: '0};
        r.is_cfg = 1'b1; r.cfg_value = 6'd3; rows.insert(rows.size(), r);
        r = '{default: '0};
        r.word = '{5'd31, 5'd31, 5'd31, 24'hFFFFFF, 24'hFFFFFF, 1'b0};
        rows.insert(rows.size(), r);
        r.word = '{5'd0, 5'd2, 5'd31, 24'd10, 24'd20, 1'b0}; rows.insert(rows.size(), r);
        r.word = '{5'd1, 5'd2, 5'd0, 24'd11, 24'd21, 1'b0}; rows.insert(rows.size(), r);
        r.word = '{5'd2, 5'd31, 5'd2, 24'd12, 24'd22, 1'b1}; rows.insert(rows.size(), r);
        r.word = '{5'd2, 5'd0, 5'd2, 24'h800000, 24'h000001, 1'b1};
        rows.insert(rows.size(), r);

        counts = '{63, 1, 32, 0, 5, 17, 45, 2, 24, 9, 3, 32, 6};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                end_words();
                wait_drained();
                reg_write(PADDR_W'(0), {26'($urandom), rows[i].cfg_value});
            end
            else
                send_word(rows[i].word, rows[i].typed, rows[i].typed_place);
        end
        end_words();

        sent = 0;
        foreach (counts[p])
        begin
            wait_drained();
            if (p == 1)
                reg_write(PADDR_W'(4), $urandom);
            reg_write(PADDR_W'(0), {26'($urandom), 6'(counts[p])});
            n = (counts[p] == 0) ? 1 : ((counts[p] > SLOTS) ? SLOTS : counts[p]);
            sets = (n >= SLOTS) ? 2 : ((16 / n > 0) ? 16 / n : 1);
            if (p == 0)
                long_hold_armed = 1'b1;
            if (p >= counts.size() - 2)
                idling_on = 1'b0;
            repeat (sets)
            begin
                send_set(n);
                sent += n;
            end
            end_words();
        end

        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("sequence_pair_pack_core test passed");
        else
            $display("sequence_pair_pack_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
